FILE: sv/sp2oam_pkg.sv
// ----------------------------------------------------------------------------
// sp2oam_pkg
// Shared constants, codes and types of the sprite-piece to OAM writer.
// ----------------------------------------------------------------------------
package sp2oam_pkg;

	localparam int ENTRY_COUNT = 128;
	localparam int NEXT_W      = 8;
	localparam int ENTRY_W     = 7;
	localparam int WORD_W      = 4;
	localparam int HIGH_DEPTH  = 16;

	localparam logic [NEXT_W-1:0] ENTRY_END = NEXT_W'(ENTRY_COUNT);

	localparam logic [15:0] ATTR_MASK = 16'hF1FF;
	localparam logic [15:0] PARK_X    = 16'h0180;
	localparam logic [7:0]  PARK_Y    = 8'hE0;
	localparam logic [7:0]  WRAP_Y    = 8'hF0;
	localparam logic [7:0]  OFF_LIMIT = 8'hE0;

	typedef enum logic [0:0] {
		REQ_PIECE = 1'b0,
		REQ_START = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		CLIP_NONE     = 3'd0,
		CLIP_PARK_OFF = 3'd1,
		CLIP_PARK_ON  = 3'd2,
		CLIP_WRAP_MIS = 3'd3,
		CLIP_WRAP_HIT = 3'd4
	} clip_t;

	typedef enum logic [1:0] {
		TILE_PASS = 2'd0,
		TILE_MASK = 2'd1,
		TILE_ADD  = 2'd2
	} tile_t;

	typedef struct packed {
		logic              fire;
		logic              start;
		logic              stop;
		logic [ENTRY_W-1:0] new_index;
		logic [1:0]        pair;
	} upd_t;

	typedef struct packed {
		logic               drop;
		logic [ENTRY_W-1:0] idx;
		logic [WORD_W-1:0]  word_index;
		logic [15:0]        word_new;
	} stat_t;

	typedef logic [(1<<ENTRY_W)-1:0][NEXT_W-1:0] mod_table_t;

	function automatic mod_table_t build_mod_table();
		mod_table_t t;
		for (int i = 0; i < (1 << ENTRY_W); i++) begin
			t[i] = NEXT_W'(i % ENTRY_COUNT);
		end
		return t;
	endfunction

	localparam mod_table_t MOD_TABLE = build_mod_table();

endpackage

FILE: sv/sprite_piece_to_oam_writer.sv
// ----------------------------------------------------------------------------
// sprite_piece_to_oam_writer
// Turns one sprite-map piece per beat into one sprite-attribute entry, or a
// dropped result, and keeps the entry pointer and the high table.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | into      | in_valid / in_stall  | req_type .. new_index
// out     | out of    | out_valid / out_stall| dropped .. high_word
//
// A beat is held in the input register, then reaches the result register
// on the edge where the pointer and high table update. One beat is taken
// per cycle unless the output stalls; pointer and table feed the next beat.
// Reset clears the pointer, the high table and both valid flags.
// A stall on the output holds both registers and raises in_stall once the
// input register is full.
// ----------------------------------------------------------------------------
module sprite_piece_to_oam_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [15:0] x_word,
	input  logic [7:0]  y_offset,
	input  logic [15:0] attr_word,
	input  logic [15:0] base_x,
	input  logic [7:0]  base_y,
	input  logic [15:0] chr_or,
	input  logic [15:0] tile_add,
	input  logic [2:0]  clip_mode,
	input  logic [1:0]  tile_mode,
	input  logic        stop_at_end,
	input  logic [6:0]  new_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        dropped,
	output logic [6:0]  entry_index,
	output logic [7:0]  x_low,
	output logic [7:0]  y_out,
	output logic [15:0] attr_out,
	output logic [3:0]  high_word_index,
	output logic [15:0] high_word
);

	logic        valid_s1;
	logic        req_s1;
	logic [15:0] x_word_s1;
	logic [7:0]  y_offset_s1;
	logic [15:0] attr_word_s1;
	logic [15:0] base_x_s1;
	logic [7:0]  base_y_s1;
	logic [15:0] chr_or_s1;
	logic [15:0] tile_add_s1;
	logic [2:0]  clip_mode_s1;
	logic [1:0]  tile_mode_s1;
	logic        stop_s1;
	logic [6:0]  new_index_s1;

	logic        out_valid_q;
	logic        advance;
	logic        load_s1;

	logic [7:0]  c_x_low;
	logic [7:0]  c_y_out;
	logic [15:0] c_attr;
	logic [1:0]  c_pair;

	sp2oam_pkg::upd_t  upd;
	sp2oam_pkg::stat_t stat;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1       <= req_type;
			x_word_s1    <= x_word;
			y_offset_s1  <= y_offset;
			attr_word_s1 <= attr_word;
			base_x_s1    <= base_x;
			base_y_s1    <= base_y;
			chr_or_s1    <= chr_or;
			tile_add_s1  <= tile_add;
			clip_mode_s1 <= clip_mode;
			tile_mode_s1 <= tile_mode;
			stop_s1      <= stop_at_end;
			new_index_s1 <= new_index;
		end
	end

	sp2oam_calc u_calc (
		.x_word    (x_word_s1),
		.y_offset  (y_offset_s1),
		.attr_word (attr_word_s1),
		.base_x    (base_x_s1),
		.base_y    (base_y_s1),
		.chr_or    (chr_or_s1),
		.tile_add  (tile_add_s1),
		.clip_mode (clip_mode_s1),
		.tile_mode (tile_mode_s1),
		.x_low     (c_x_low),
		.y_out     (c_y_out),
		.attr_out  (c_attr),
		.pair      (c_pair)
	);

	assign upd.fire      = valid_s1 && advance;
	assign upd.start     = (req_s1 == sp2oam_pkg::REQ_START);
	assign upd.stop      = stop_s1;
	assign upd.new_index = new_index_s1;
	assign upd.pair      = c_pair;

	sp2oam_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.fire) begin
			dropped <= stat.drop;
			if (stat.drop) begin
				entry_index     <= '0;
				x_low           <= '0;
				y_out           <= '0;
				attr_out        <= '0;
				high_word_index <= '0;
				high_word       <= '0;
			end else begin
				entry_index     <= stat.idx;
				x_low           <= c_x_low;
				y_out           <= c_y_out;
				attr_out        <= c_attr;
				high_word_index <= stat.word_index;
				high_word       <= stat.word_new;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/sp2oam_calc.sv
// ----------------------------------------------------------------------------
// sp2oam_calc
// Position, vertical clip, attribute and high-pair logic for one piece.
// ----------------------------------------------------------------------------
module sp2oam_calc (
	input  logic [15:0] x_word,
	input  logic [7:0]  y_offset,
	input  logic [15:0] attr_word,
	input  logic [15:0] base_x,
	input  logic [7:0]  base_y,
	input  logic [15:0] chr_or,
	input  logic [15:0] tile_add,
	input  logic [2:0]  clip_mode,
	input  logic [1:0]  tile_mode,
	output logic [7:0]  x_low,
	output logic [7:0]  y_out,
	output logic [15:0] attr_out,
	output logic [1:0]  pair
);

	logic [15:0] x_sum;
	logic [15:0] x_fin;
	logic [8:0]  y9;
	logic        neg;
	logic        carry;
	logic        off;

	assign x_sum = base_x + x_word;
	assign y9    = {1'b0, base_y} + {1'b0, y_offset};
	assign neg   = y_offset[7];
	assign carry = y9[8];

	always_comb begin
		if (!neg) begin
			off = (y9 >= {1'b0, sp2oam_pkg::OFF_LIMIT});
		end else if (carry) begin
			off = (y9[7:0] >= sp2oam_pkg::OFF_LIMIT);
		end else begin
			off = (y9[7:0] < sp2oam_pkg::OFF_LIMIT);
		end
	end

	always_comb begin
		x_fin = x_sum;
		y_out = y9[7:0];
		case (clip_mode)
			sp2oam_pkg::CLIP_PARK_OFF: begin
				if (off) begin
					x_fin = sp2oam_pkg::PARK_X;
					y_out = sp2oam_pkg::PARK_Y;
				end
			end
			sp2oam_pkg::CLIP_PARK_ON: begin
				if (!off) begin
					x_fin = sp2oam_pkg::PARK_X;
					y_out = sp2oam_pkg::PARK_Y;
				end
			end
			sp2oam_pkg::CLIP_WRAP_MIS: begin
				if (carry != neg) begin
					y_out = sp2oam_pkg::WRAP_Y;
				end
			end
			sp2oam_pkg::CLIP_WRAP_HIT: begin
				if (carry == neg) begin
					y_out = sp2oam_pkg::WRAP_Y;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (tile_mode)
			sp2oam_pkg::TILE_MASK: attr_out = chr_or | (attr_word & sp2oam_pkg::ATTR_MASK);
			sp2oam_pkg::TILE_ADD:  attr_out = chr_or | (tile_add + attr_word);
			default:               attr_out = attr_word;
		endcase
	end

	assign x_low = x_fin[7:0];
	assign pair  = {x_word[15], x_fin[8]};

endmodule

FILE: sv/sp2oam_state.sv
// ----------------------------------------------------------------------------
// sp2oam_state
// Entry pointer and the sixteen-word high table, with their update rules.
// ----------------------------------------------------------------------------
module sp2oam_state (
	input  logic              clk,
	input  logic              arst_n,
	input  sp2oam_pkg::upd_t  upd,
	output sp2oam_pkg::stat_t stat
);

	logic [sp2oam_pkg::NEXT_W-1:0]  next_entry_q;
	logic [15:0]                    high_q [sp2oam_pkg::HIGH_DEPTH];
	logic                           full;
	logic [sp2oam_pkg::ENTRY_W-1:0] idx;
	logic [sp2oam_pkg::WORD_W-1:0]  w;
	logic [15:0]                    word_new;
	logic [sp2oam_pkg::NEXT_W-1:0]  inc;
	logic [sp2oam_pkg::NEXT_W-1:0]  next_adv;
	logic                           drop;

	assign full     = (next_entry_q >= sp2oam_pkg::ENTRY_END);
	assign idx      = full ? '0 : next_entry_q[sp2oam_pkg::ENTRY_W-1:0];
	assign w        = idx[sp2oam_pkg::ENTRY_W-1:3];
	assign word_new = high_q[w] | (16'(upd.pair) << {idx[2:0], 1'b0});
	assign inc      = {1'b0, idx} + sp2oam_pkg::NEXT_W'(1);
	assign next_adv = (!upd.stop && inc >= sp2oam_pkg::ENTRY_END) ? '0 : inc;
	assign drop     = upd.start || (full && upd.stop);

	assign stat.drop       = drop;
	assign stat.idx        = idx;
	assign stat.word_index = w;
	assign stat.word_new   = word_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_entry_q <= '0;
			for (int i = 0; i < sp2oam_pkg::HIGH_DEPTH; i++) begin
				high_q[i] <= '0;
			end
		end else if (upd.fire) begin
			if (upd.start) begin
				next_entry_q <= sp2oam_pkg::MOD_TABLE[upd.new_index];
				for (int i = 0; i < sp2oam_pkg::HIGH_DEPTH; i++) begin
					high_q[i] <= '0;
				end
			end else if (!drop) begin
				high_q[w]    <= word_new;
				next_entry_q <= next_adv;
			end
		end
	end

endmodule
